/* rtl/tccw_pkg.sv */
package tccw_pkg;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int ATTR_W    = 2 * COLOR_W;
    localparam int INDEX_W   = 11;
    localparam int CELL_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int TAB_STEP  = 8;

    localparam logic [CHAR_W-1:0] CODE_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LF  = 8'h0a;
    localparam logic [CHAR_W-1:0] CODE_CR  = 8'h0d;

    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'hf;
    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'h0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOREGROUND = 1'b0,
        REG_BACKGROUND = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_code;
    } tccw_step_t;

    typedef struct packed {
        logic               cell_write;
        logic [INDEX_W-1:0] cell_index;
        logic [CELL_W-1:0]  cell_value;
        logic [INDEX_W-1:0] cursor_index;
    } tccw_result_t;

endpackage

/* rtl/tccw_channels.sv */
interface tccw_in_if;
    import tccw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface tccw_out_if;
    import tccw_pkg::*;

    logic               valid;
    logic               ready;
    logic               cell_write;
    logic [INDEX_W-1:0] cell_index;
    logic [CELL_W-1:0]  cell_value;
    logic [INDEX_W-1:0] cursor_index;

    modport source (output valid, output cell_write, output cell_index, output cell_value,
                    output cursor_index, input ready);
    modport sink (input valid, input cell_write, input cell_index, input cell_value,
                  input cursor_index, output ready);
endinterface

/* rtl/tccw_cursor.sv */
module tccw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tccw_pkg::tccw_step_t        step,
    input  logic                        advance,
    input  logic [tccw_pkg::ATTR_W-1:0] attr,
    output tccw_pkg::tccw_result_t      result
);
    import tccw_pkg::*;

    localparam int PROD_W = COL_W + ROW_W;

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ROW_W-1:0]  row_inc;
    logic [COL_W:0]    col_wide;
    logic [ROW_W-1:0]  row_mid;
    logic              printable;
    logic [PROD_W-1:0] cell_off;
    logic [PROD_W-1:0] cursor_off;

    // row wraps to 0 past the last row
    assign row_inc = (row_reg == ROW_W'(ROWS - 1)) ? '0 : row_reg + ROW_W'(1);

    always_comb
    begin
        col_wide  = {1'b0, col_reg};
        row_mid   = row_reg;
        printable = 1'b0;
        unique case (step.char_code)
            CODE_BS:
            begin
                if (col_reg != '0)
                begin
                    col_wide = {1'b0, col_reg} - (COL_W + 1)'(1);
                end
            end
            CODE_TAB:
            begin
                col_wide = ({1'b0, col_reg} + (COL_W + 1)'(TAB_STEP))
                           & ~(COL_W + 1)'(TAB_STEP - 1);
            end
            CODE_CR:
            begin
                col_wide = '0;
            end
            CODE_LF:
            begin
                col_wide = '0;
                row_mid  = row_inc;
            end
            default:
            begin
                printable = 1'b1;
                col_wide  = {1'b0, col_reg} + (COL_W + 1)'(1);
            end
        endcase

        // column overflow goes to the start of the next row
        if (col_wide >= (COL_W + 1)'(COLUMNS))
        begin
            col_next = '0;
            row_next = row_inc;
        end
        else
        begin
            col_next = col_wide[COL_W-1:0];
            row_next = row_mid;
        end
    end

    assign cell_off   = PROD_W'(row_reg) * PROD_W'(COLUMNS) + PROD_W'(col_reg);
    assign cursor_off = PROD_W'(row_next) * PROD_W'(COLUMNS) + PROD_W'(col_next);

    assign result.cell_write   = printable;
    assign result.cell_index   = printable ? cell_off[INDEX_W-1:0] : '0;
    assign result.cell_value   = printable ? {attr, step.char_code} : '0;
    assign result.cursor_index = cursor_off[INDEX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/tccw_out_stage.sv */
module tccw_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  tccw_pkg::tccw_result_t result,
    output logic                   free,
    tccw_out_if.source             cell_out
);
    import tccw_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    tccw_result_t data_reg;

    assign free = !valid_reg || cell_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= result;
        end
    end

    assign cell_out.valid        = valid_reg;
    assign cell_out.cell_write   = data_reg.cell_write;
    assign cell_out.cell_index   = data_reg.cell_index;
    assign cell_out.cell_value   = data_reg.cell_value;
    assign cell_out.cursor_index = data_reg.cursor_index;

endmodule

/* rtl/text_console_cursor_writer_core.sv */
// channel   | dir | payload                                            | accepted when
// ----------+-----+----------------------------------------------------+------------------
// char_in   | in  | char_code[7:0]                                     | valid && ready
// cell_out  | out | cell_write, cell_index[10:0], cell_value[15:0],    | valid && ready
//           |     | cursor_index[10:0]                                 |
// cfg       | in  | cfg_we, cfg_index[0], cfg_data[3:0]                | cfg_we
//
// one character per cycle sustained while cell_out does not stall; char_in feeds
// the input register, then one pass of cursor update and cell offset logic, then
// the result register toward cell_out; cursor state commits as the result is loaded
// reset clears the cursor to row 0, column 0 and the colors to white on black
// a stall on cell_out holds the result; char_in keeps flowing while a slot is free
module text_console_cursor_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tccw_pkg::COLOR_W-1:0]   cfg_data,
    tccw_in_if.sink                        char_in,
    tccw_out_if.source                     cell_out
);
    import tccw_pkg::*;

    // color registers, to be written only while idle; the block does not enforce it
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;

    logic         out_free;
    logic         advance;
    tccw_step_t   step;
    tccw_result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FOREGROUND_RESET;
            bg_reg <= BACKGROUND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FOREGROUND: fg_reg <= cfg_data;
                REG_BACKGROUND: bg_reg <= cfg_data;
                default:        fg_reg <= fg_reg;
            endcase
        end
    end

    // the input slot frees up whenever its item moves on to the result register
    assign advance      = in_valid_reg && out_free;
    assign char_in.ready = !in_valid_reg || out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (char_in.ready)
        begin
            in_valid_next = char_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            in_char_reg <= char_in.char_code;
        end
    end

    assign step.valid     = in_valid_reg;
    assign step.char_code = in_char_reg;

    // cursor state and per-character decode
    tccw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .advance (advance),
        .attr    ({bg_reg, fg_reg}),
        .result  (result)
    );

    // result register toward cell_out
    tccw_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_valid_reg),
        .result   (result),
        .free     (out_free),
        .cell_out (cell_out)
    );

endmodule

/* rtl/tccw_checker.sv */
module tccw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         cell_write,
    input logic [tccw_pkg::INDEX_W-1:0] cell_index,
    input logic [tccw_pkg::CELL_W-1:0]  cell_value,
    input logic [tccw_pkg::INDEX_W-1:0] cursor_index
);
    import tccw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam bit FITS  = CELLS <= (1 << INDEX_W);

    // stalled transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_index) && $stable(cursor_index)
                                    && $stable(cell_value) && $stable(cell_write))
        else $error("stalled transaction changed");

    // control codes carry a zero cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cell_write |-> cell_index == '0 && cell_value == '0)
        else $error("control code with nonzero cell fields");

    // a written cell never holds a cursor control code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cell_write |-> cell_value[CHAR_W-1:0] != CODE_BS
            && cell_value[CHAR_W-1:0] != CODE_TAB && cell_value[CHAR_W-1:0] != CODE_LF
            && cell_value[CHAR_W-1:0] != CODE_CR)
        else $error("control code written to screen");

    // cursor and cell stay on screen when the screen fits the index width
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && FITS |-> 32'(cursor_index) < CELLS && 32'(cell_index) < CELLS)
        else $error("index off screen");

endmodule

bind text_console_cursor_writer_core tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (cell_out.valid),
    .out_ready    (cell_out.ready),
    .cell_write   (cell_out.cell_write),
    .cell_index   (cell_out.cell_index),
    .cell_value   (cell_out.cell_value),
    .cursor_index (cell_out.cursor_index)
);
